// File: design/vsir_pkg.sv
// Shared types and constants of the video signal and interrupt register block.
package vsir_pkg;

   localparam int unsigned KIND_W    = 4;
   localparam int unsigned ADDR_W    = 16;
   localparam int unsigned DATA_W    = 64;
   localparam int unsigned FIFO_W    = 2;
   localparam int unsigned MASK_W    = 5;
   localparam int unsigned ID_W      = 32;
   localparam int unsigned REQ_TDATA_W = 88;
   localparam int unsigned RSP_TDATA_W = 72;

   localparam logic [ADDR_W-1:0] ADDR_MASK     = 16'h13F0;
   localparam logic [ADDR_W-1:0] ADDR_SYNCV    = 16'h0060;
   localparam logic [ADDR_W-1:0] ADDR_SMODE2   = 16'h0070;
   localparam logic [ADDR_W-1:0] ADDR_DISPFB2  = 16'h0090;
   localparam logic [ADDR_W-1:0] ADDR_EXTWRITE = 16'h00D0;
   localparam logic [ADDR_W-1:0] ADDR_BGCOLOR  = 16'h00E0;
   localparam logic [ADDR_W-1:0] ADDR_CSR      = 16'h1000;
   localparam logic [ADDR_W-1:0] ADDR_IMR      = 16'h1010;
   localparam logic [ADDR_W-1:0] ADDR_BUSDIR   = 16'h1040;
   localparam logic [ADDR_W-1:0] ADDR_SIGLBLID = 16'h1080;
   localparam logic [ADDR_W-1:0] DRAW_SIGNAL   = 16'h0060;
   localparam logic [ADDR_W-1:0] DRAW_FINISH   = 16'h0061;
   localparam logic [ADDR_W-1:0] DRAW_LABEL    = 16'h0062;

   localparam logic [7:0] GS_REV = 8'h1B;
   localparam logic [7:0] GS_ID  = 8'h55;

   localparam int unsigned CSR_SOFT_RESET_BIT = 9;

   localparam int unsigned MASK_FINISH = 1;
   localparam int unsigned MASK_HSYNC  = 2;
   localparam int unsigned MASK_VSYNC  = 3;

   typedef enum logic [KIND_W-1:0] {
      KIND_WR64   = 4'd0,
      KIND_WR32   = 4'd1,
      KIND_RD64   = 4'd2,
      KIND_RD32   = 4'd3,
      KIND_DRAW   = 4'd4,
      KIND_HBLANK = 4'd5,
      KIND_VBLANK = 4'd6,
      KIND_FINISH = 4'd7,
      KIND_FIELD  = 4'd8
   } kind_type;

   typedef struct packed {
      logic              signal_flag;
      logic              signal_wait;
      logic              signal_int_due;
      logic              finish_flag;
      logic              finish_request;
      logic              hblank_flag;
      logic              vblank_flag;
      logic              odd_field;
      logic [MASK_W-1:0] int_masks;
      logic [ID_W-1:0]   signal_id;
      logic [ID_W-1:0]   label_id;
      logic [ID_W-1:0]   backup_signal_id;
      logic              front_porch_odd;
   } state_type;

   typedef struct packed {
      logic              error;
      logic              handled;
      logic              irq;
      logic [DATA_W-1:0] rdata;
   } result_type;

   localparam state_type STATE_RESET = '{
      signal_flag:        1'b0,
      signal_wait:        1'b0,
      signal_int_due:     1'b0,
      finish_flag:        1'b0,
      finish_request:     1'b0,
      hblank_flag:        1'b0,
      vblank_flag:        1'b0,
      odd_field:          1'b1,
      int_masks:          '1,
      signal_id:          '0,
      label_id:           '0,
      backup_signal_id:   '0,
      front_porch_odd:    1'b0
   };

endpackage

// File: design/vsir_exec.sv
// Next-state and result logic for one request of the register block.
module vsir_exec (
   input  vsir_pkg::state_type                 state_cur,
   input  logic [vsir_pkg::KIND_W-1:0]         kind,
   input  logic [vsir_pkg::ADDR_W-1:0]         addr,
   input  logic [vsir_pkg::DATA_W-1:0]         wdata,
   input  logic [vsir_pkg::FIFO_W-1:0]         fifo_state,
   output vsir_pkg::state_type                 state_nxt,
   output vsir_pkg::result_type                result
);

   logic [vsir_pkg::ADDR_W-1:0] addr_m;
   logic [vsir_pkg::DATA_W-1:0] wval;
   logic [vsir_pkg::DATA_W-1:0] status;
   logic [vsir_pkg::DATA_W-1:0] rd_word;
   logic [vsir_pkg::ID_W-1:0]   draw_mask;
   logic [vsir_pkg::ID_W-1:0]   draw_bits;
   logic                        is_csr;
   logic                        is_imr;
   logic                        is_ids;

   assign addr_m    = addr & vsir_pkg::ADDR_MASK;
   assign draw_mask = wdata[63:32];
   assign draw_bits = wdata[31:0] & draw_mask;
   assign is_csr    = (addr_m == vsir_pkg::ADDR_CSR);
   assign is_imr    = (addr_m == vsir_pkg::ADDR_IMR);
   assign is_ids    = (addr_m == vsir_pkg::ADDR_SIGLBLID);

   always_comb begin
      status        = '0;
      status[0]     = state_cur.signal_flag;
      status[1]     = state_cur.finish_flag;
      status[2]     = state_cur.hblank_flag;
      status[3]     = state_cur.vblank_flag;
      status[13]    = state_cur.odd_field;
      status[15:14] = fifo_state;
      status[23:16] = vsir_pkg::GS_REV;
      status[31:24] = vsir_pkg::GS_ID;
      rd_word = is_ids ? {state_cur.label_id, state_cur.signal_id} : status;
   end

   always_comb begin
      state_nxt = state_cur;
      result    = '0;
      wval      = (kind == vsir_pkg::KIND_WR32) ? {32'b0, wdata[31:0]} : wdata;
      case (kind)
         vsir_pkg::KIND_WR64, vsir_pkg::KIND_WR32: begin
            if (is_csr) begin
               if (wval[0]) begin
                  state_nxt.signal_flag = 1'b0;
                  if (state_cur.signal_wait) begin
                     state_nxt.signal_wait      = 1'b0;
                     state_nxt.signal_id        = state_cur.backup_signal_id;
                     state_nxt.signal_flag      = 1'b1;
                     state_nxt.signal_int_due   = 1'b1;
                  end else begin
                     state_nxt.signal_int_due = 1'b0;
                  end
               end
               if (wval[1]) begin
                  state_nxt.finish_flag = 1'b0;
               end
               if (wval[2]) begin
                  state_nxt.hblank_flag = 1'b0;
               end
               if (wval[3]) begin
                  state_nxt.vblank_flag = 1'b0;
               end
               if (wval[vsir_pkg::CSR_SOFT_RESET_BIT]) begin
                  state_nxt           = vsir_pkg::STATE_RESET;
                  state_nxt.odd_field = state_cur.odd_field;
               end
            end else if (is_imr) begin
               state_nxt.int_masks = wval[12:8];
            end else if (is_ids) begin
               state_nxt.signal_id = wval[31:0];
               if (kind == vsir_pkg::KIND_WR64) begin
                  state_nxt.label_id = wval[63:32];
               end
            end else if (kind == vsir_pkg::KIND_WR64) begin
               if (addr_m == vsir_pkg::ADDR_BUSDIR) begin
                  result.error = 1'b0;
               end else if (addr_m <= vsir_pkg::ADDR_BGCOLOR) begin
                  if (addr_m == vsir_pkg::ADDR_SYNCV) begin
                     state_nxt.front_porch_odd = wval[0];
                  end
                  result.error = (addr_m == vsir_pkg::ADDR_EXTWRITE) && wval[0];
               end else begin
                  result.error = 1'b1;
               end
            end else begin
               result.error = !(addr_m inside {vsir_pkg::ADDR_SMODE2, vsir_pkg::ADDR_DISPFB2,
                                               vsir_pkg::ADDR_BGCOLOR});
            end
         end
         vsir_pkg::KIND_RD64: begin
            result.rdata = rd_word;
         end
         vsir_pkg::KIND_RD32: begin
            result.rdata = addr[2] ? {32'b0, rd_word[63:32]} : {32'b0, rd_word[31:0]};
         end
         vsir_pkg::KIND_DRAW: begin
            case (addr)
               vsir_pkg::DRAW_SIGNAL: begin
                  result.handled = 1'b1;
                  if (state_cur.signal_flag) begin
                     state_nxt.signal_wait      = 1'b1;
                     state_nxt.backup_signal_id =
                        (state_cur.signal_id & ~draw_mask) | draw_bits;
                  end else begin
                     state_nxt.signal_flag = 1'b1;
                     state_nxt.signal_id   = (state_cur.signal_id & ~draw_mask) | draw_bits;
                  end
               end
               vsir_pkg::DRAW_FINISH: begin
                  result.handled           = 1'b1;
                  state_nxt.finish_request = 1'b1;
               end
               vsir_pkg::DRAW_LABEL: begin
                  result.handled     = 1'b1;
                  state_nxt.label_id = (state_cur.label_id & ~draw_mask) | draw_bits;
               end
               default: begin
                  result.handled = 1'b0;
               end
            endcase
         end
         vsir_pkg::KIND_HBLANK: begin
            if (!state_cur.hblank_flag) begin
               state_nxt.hblank_flag = 1'b1;
               result.irq = !state_cur.int_masks[vsir_pkg::MASK_HSYNC];
            end
         end
         vsir_pkg::KIND_VBLANK: begin
            if (!state_cur.vblank_flag) begin
               state_nxt.vblank_flag = 1'b1;
               result.irq = !state_cur.int_masks[vsir_pkg::MASK_VSYNC];
            end
         end
         vsir_pkg::KIND_FINISH: begin
            if (state_cur.finish_request && !state_cur.finish_flag) begin
               state_nxt.finish_request = 1'b0;
               state_nxt.finish_flag    = 1'b1;
               result.irq = !state_cur.int_masks[vsir_pkg::MASK_FINISH];
            end
         end
         vsir_pkg::KIND_FIELD: begin
            state_nxt.odd_field = state_cur.front_porch_odd ? !state_cur.odd_field : 1'b1;
         end
         default: begin
            state_nxt = state_cur;
         end
      endcase
   end

endmodule

// File: design/video_signal_interrupt_regs_unit.sv
// Top level of the video signal, label and interrupt register block.
// Each request is captured in an input register and then, in the cycle in which it moves
// to the result register, updates the flags, masks and ids; one request is accepted every
// clock cycle and its response is presented from the result register until it is taken.
// The block keeps taking requests while a response waits, and stalls only when both
// registers are full and the response side holds back. Requests are served strictly
// in order.
module video_signal_interrupt_regs_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // Fields from bit 0: addr (16), wdata (64), fifo_state (2), zero fill (6).
   input  logic [vsir_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // Fields from bit 0: req_type (4).
   input  logic [vsir_pkg::KIND_W-1:0]          req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // Fields from bit 0: rdata (64), irq (1), handled (1), error (1), zero fill (5).
   output logic [vsir_pkg::RSP_TDATA_W-1:0]     rsp_tdata
);

   logic                            in_valid_ff;
   logic [vsir_pkg::KIND_W-1:0]     in_kind_ff;
   logic [vsir_pkg::ADDR_W-1:0]     in_addr_ff;
   logic [vsir_pkg::DATA_W-1:0]     in_wdata_ff;
   logic [vsir_pkg::FIFO_W-1:0]     in_fifo_ff;
   logic                            out_valid_ff;
   vsir_pkg::result_type            out_result_ff;
   vsir_pkg::state_type             state_ff;
   vsir_pkg::state_type             state_in;
   vsir_pkg::result_type            result_in;
   logic                            advance;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'b0, out_result_ff};

   vsir_exec u_exec (
      .state_cur  (state_ff),
      .kind       (in_kind_ff),
      .addr       (in_addr_ff),
      .wdata      (in_wdata_ff),
      .fifo_state (in_fifo_ff),
      .state_nxt  (state_in),
      .result     (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= vsir_pkg::STATE_RESET;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            state_ff     <= state_in;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_kind_ff  <= req_tuser;
         in_addr_ff  <= req_tdata[15:0];
         in_wdata_ff <= req_tdata[79:16];
         in_fifo_ff  <= req_tdata[81:80];
      end
      if (advance) begin
         out_result_ff <= result_in;
      end
   end

endmodule

// File: test/tb_video_signal_interrupt_regs_unit.sv
// Self-checking testbench of the video signal, label and interrupt register block.
package vsir_mirror_pkg;

   localparam logic [vsir_pkg::KIND_W-1:0] KIND_UNUSED = 4'hF;

   typedef struct {
      logic [vsir_pkg::KIND_W-1:0] kind;
      logic [vsir_pkg::ADDR_W-1:0] addr;
      logic [vsir_pkg::DATA_W-1:0] wdata;
      logic [vsir_pkg::FIFO_W-1:0] fifo;
   } request_type;

   typedef struct {
      logic [vsir_pkg::DATA_W-1:0] rdata;
      logic                        irq;
      logic                        handled;
      logic                        error;
   } response_type;

   // Keeps its own copy of the flags, masks and ids and predicts each response.
   class register_mirror_type;
      logic                        signal_flag, signal_wait, signal_int_due;
      logic                        finish_flag, finish_request, hblank_flag, vblank_flag;
      logic                        odd_field, front_porch_odd;
      logic [vsir_pkg::MASK_W-1:0] int_masks;
      logic [vsir_pkg::ID_W-1:0]   signal_id, label_id, backup_signal_id;
      response_type                expected_responses[$];
      int unsigned                 mismatch_count;

      function new();
         restore_defaults();
         odd_field = 1'b1;
         mismatch_count = 0;
      endfunction

      // The odd-field bit survives a soft reset.
      function void restore_defaults();
         signal_flag = 1'b0;
         signal_wait = 1'b0;
         signal_int_due = 1'b0;
         finish_flag = 1'b0;
         finish_request = 1'b0;
         hblank_flag = 1'b0;
         vblank_flag = 1'b0;
         front_porch_odd = 1'b0;
         int_masks = '1;
         signal_id = '0;
         label_id = '0;
         backup_signal_id = '0;
      endfunction

      function void ack_events(logic [vsir_pkg::DATA_W-1:0] v);
         if (v[0]) begin
            signal_flag = 1'b0;
            if (signal_wait) begin
               signal_wait = 1'b0;
               signal_id = backup_signal_id;
               signal_flag = 1'b1;
               signal_int_due = 1'b1;
            end else begin
               signal_int_due = 1'b0;
            end
         end
         if (v[1]) finish_flag = 1'b0;
         if (v[2]) hblank_flag = 1'b0;
         if (v[3]) vblank_flag = 1'b0;
         if (v[vsir_pkg::CSR_SOFT_RESET_BIT]) restore_defaults();
      endfunction

      function logic [vsir_pkg::DATA_W-1:0] status_word(logic [vsir_pkg::ADDR_W-1:0] a,
                                                        logic [vsir_pkg::FIFO_W-1:0] fifo);
         if ((a & vsir_pkg::ADDR_MASK) == vsir_pkg::ADDR_SIGLBLID) return {label_id, signal_id};
         return {32'b0, vsir_pkg::GS_ID, vsir_pkg::GS_REV, fifo, odd_field, 9'b0,
                 vblank_flag, hblank_flag, finish_flag, signal_flag};
      endfunction

      function void note_request(request_type r);
         response_type                rsp;
         logic [vsir_pkg::ADDR_W-1:0] a;
         logic [vsir_pkg::DATA_W-1:0] v;
         logic [vsir_pkg::DATA_W-1:0] word;
         logic [vsir_pkg::ID_W-1:0]   m, nv;
         logic                        wide;
         rsp = '{rdata: '0, irq: 1'b0, handled: 1'b0, error: 1'b0};
         case (r.kind)
            vsir_pkg::KIND_WR64, vsir_pkg::KIND_WR32: begin
               wide = (r.kind == vsir_pkg::KIND_WR64);
               a = r.addr & vsir_pkg::ADDR_MASK;
               v = wide ? r.wdata : {32'b0, r.wdata[31:0]};
               if (a == vsir_pkg::ADDR_CSR) begin
                  ack_events(v);
               end else if (a == vsir_pkg::ADDR_IMR) begin
                  int_masks = v[12:8];
               end else if (a == vsir_pkg::ADDR_SIGLBLID) begin
                  signal_id = v[31:0];
                  if (wide) label_id = v[63:32];
               end else if (wide && a <= vsir_pkg::ADDR_BGCOLOR) begin
                  if (a == vsir_pkg::ADDR_SYNCV) front_porch_odd = v[0];
                  rsp.error = (a == vsir_pkg::ADDR_EXTWRITE) && v[0];
               end else if (wide ? (a != vsir_pkg::ADDR_BUSDIR)
                                 : !(a inside {vsir_pkg::ADDR_SMODE2, vsir_pkg::ADDR_DISPFB2,
                                               vsir_pkg::ADDR_BGCOLOR})) begin
                  rsp.error = 1'b1;
               end
            end
            vsir_pkg::KIND_RD64: begin
               rsp.rdata = status_word(r.addr, r.fifo);
            end
            vsir_pkg::KIND_RD32: begin
               word = status_word(r.addr, r.fifo);
               rsp.rdata = r.addr[2] ? {32'b0, word[63:32]} : {32'b0, word[31:0]};
            end
            vsir_pkg::KIND_DRAW: begin
               m = r.wdata[63:32];
               nv = r.wdata[31:0] & m;
               rsp.handled = 1'b1;
               if (r.addr == vsir_pkg::DRAW_SIGNAL) begin
                  if (signal_flag) begin
                     signal_wait = 1'b1;
                     backup_signal_id = (signal_id & ~m) | nv;
                  end else begin
                     signal_flag = 1'b1;
                     signal_id = (signal_id & ~m) | nv;
                  end
               end else if (r.addr == vsir_pkg::DRAW_FINISH) begin
                  finish_request = 1'b1;
               end else if (r.addr == vsir_pkg::DRAW_LABEL) begin
                  label_id = (label_id & ~m) | nv;
               end else begin
                  rsp.handled = 1'b0;
               end
            end
            vsir_pkg::KIND_HBLANK: begin
               if (!hblank_flag) begin
                  hblank_flag = 1'b1;
                  rsp.irq = ~int_masks[vsir_pkg::MASK_HSYNC];
               end
            end
            vsir_pkg::KIND_VBLANK: begin
               if (!vblank_flag) begin
                  vblank_flag = 1'b1;
                  rsp.irq = ~int_masks[vsir_pkg::MASK_VSYNC];
               end
            end
            vsir_pkg::KIND_FINISH: begin
               if (finish_request && !finish_flag) begin
                  finish_request = 1'b0;
                  finish_flag = 1'b1;
                  rsp.irq = ~int_masks[vsir_pkg::MASK_FINISH];
               end
            end
            vsir_pkg::KIND_FIELD: begin
               odd_field = front_porch_odd ? ~odd_field : 1'b1;
            end
            default: begin
            end
         endcase
         expected_responses.push_back(rsp);
      endfunction

      function void check_response(response_type got);
         response_type want;
         if (expected_responses.size() == 0) begin
            $error("response with no request outstanding: rdata %h", got.rdata);
            mismatch_count++;
            return;
         end
         want = expected_responses.pop_front();
         if (got.rdata !== want.rdata) begin
            $error("rdata: expected %h, got %h", want.rdata, got.rdata);
            mismatch_count++;
         end
         if (got.irq !== want.irq) begin
            $error("irq: expected %b, got %b", want.irq, got.irq);
            mismatch_count++;
         end
         if (got.handled !== want.handled) begin
            $error("handled: expected %b, got %b", want.handled, got.handled);
            mismatch_count++;
         end
         if (got.error !== want.error) begin
            $error("error: expected %b, got %b", want.error, got.error);
            mismatch_count++;
         end
      endfunction

      function int unsigned waiting();
         return expected_responses.size();
      endfunction
   endclass
endpackage

module tb_video_signal_interrupt_regs_unit;

   localparam int unsigned RANDOM_ITEMS   = 1700;
   localparam int unsigned HOLD_START     = 1500;
   localparam int unsigned HOLD_CYCLES    = 400;
   localparam int unsigned QUIET_LIMIT    = 2000;
   localparam int unsigned SETTLE_CYCLES  = 16;

   logic                             clock;
   logic                             reset      = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [vsir_pkg::REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [vsir_pkg::KIND_W-1:0]      req_tuser  = '0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [vsir_pkg::RSP_TDATA_W-1:0] rsp_tdata;

   vsir_mirror_pkg::register_mirror_type mirror = new();

   video_signal_interrupt_regs_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            mirror.note_request('{kind: req_tuser, addr: req_tdata[15:0],
                                  wdata: req_tdata[79:16], fifo: req_tdata[81:80]});
         end
         if (rsp_tvalid && rsp_tready) begin
            mirror.check_response('{rdata: rsp_tdata[63:0], irq: rsp_tdata[64],
                                    handled: rsp_tdata[65], error: rsp_tdata[66]});
         end
      end
   end

   task automatic send_request(logic [vsir_pkg::KIND_W-1:0] kind,
                               logic [vsir_pkg::ADDR_W-1:0] addr,
                               logic [vsir_pkg::DATA_W-1:0] wdata,
                               logic [vsir_pkg::FIFO_W-1:0] fifo);
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {6'b0, fifo, wdata, addr};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain_responses();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (mirror.waiting() != 0);
   endtask

   function automatic vsir_mirror_pkg::request_type random_request();
      vsir_mirror_pkg::request_type r;
      int unsigned                  pick;
      logic [vsir_pkg::ADDR_W-1:0]  noise;
      pick = $urandom_range(0, 99);
      noise = ($urandom_range(0, 1) != 0) ? (16'($urandom) & ~vsir_pkg::ADDR_MASK) : '0;
      r.addr = 16'($urandom);
      r.wdata = {$urandom, $urandom};
      r.fifo = 2'($urandom);
      if (pick < 16) begin
         r.kind = vsir_pkg::KIND_WR64;
         case ($urandom_range(0, 7))
            0, 1: r.addr = vsir_pkg::ADDR_CSR | noise;
            2: r.addr = vsir_pkg::ADDR_IMR | noise;
            3: r.addr = vsir_pkg::ADDR_SIGLBLID | noise;
            4: r.addr = vsir_pkg::ADDR_SYNCV | noise;
            5: r.addr = vsir_pkg::ADDR_EXTWRITE | noise;
            6: r.addr = 16'($urandom_range(0, 15) << 4) | noise;
            default: begin
            end
         endcase
      end else if (pick < 26) begin
         r.kind = vsir_pkg::KIND_WR32;
         case ($urandom_range(0, 7))
            0, 1: r.addr = vsir_pkg::ADDR_CSR | noise;
            2: r.addr = vsir_pkg::ADDR_IMR | noise;
            3: r.addr = vsir_pkg::ADDR_SIGLBLID | noise;
            4: r.addr = vsir_pkg::ADDR_SMODE2 | noise;
            5: r.addr = vsir_pkg::ADDR_DISPFB2 | noise;
            6: r.addr = vsir_pkg::ADDR_BGCOLOR | noise;
            default: begin
            end
         endcase
      end else if (pick < 50) begin
         r.kind = (pick < 40) ? vsir_pkg::KIND_RD64 : vsir_pkg::KIND_RD32;
         if ($urandom_range(0, 1) != 0) r.addr = vsir_pkg::ADDR_SIGLBLID | noise;
      end else if (pick < 72) begin
         r.kind = vsir_pkg::KIND_DRAW;
         case ($urandom_range(0, 5))
            0, 1: r.addr = vsir_pkg::DRAW_SIGNAL;
            2: r.addr = vsir_pkg::DRAW_FINISH;
            3: r.addr = vsir_pkg::DRAW_LABEL;
            default: begin
            end
         endcase
         case ($urandom_range(0, 3))
            0: r.wdata[63:32] = '1;
            1: r.wdata[63:32] = '0;
            default: begin
            end
         endcase
      end else if (pick < 80) begin
         r.kind = vsir_pkg::KIND_HBLANK;
      end else if (pick < 88) begin
         r.kind = vsir_pkg::KIND_VBLANK;
      end else if (pick < 95) begin
         r.kind = vsir_pkg::KIND_FINISH;
      end else if (pick < 98) begin
         r.kind = vsir_pkg::KIND_FIELD;
      end else begin
         r.kind = 4'($urandom_range(vsir_pkg::KIND_FIELD + 1,
                                    vsir_mirror_pkg::KIND_UNUSED));
      end
      // Soft resets are kept rare so that the flags can build up between them.
      if ((r.kind == vsir_pkg::KIND_WR64 || r.kind == vsir_pkg::KIND_WR32) &&
          (r.addr & vsir_pkg::ADDR_MASK) == vsir_pkg::ADDR_CSR &&
          $urandom_range(0, 24) != 0) begin
         r.wdata[vsir_pkg::CSR_SOFT_RESET_BIT] = 1'b0;
      end
      return r;
   endfunction

   initial begin : request_source
      vsir_mirror_pkg::request_type r;
      int unsigned                  counted;
      int unsigned                  burst;
      bit                           paused;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      send_request(vsir_pkg::KIND_RD64, 16'h0000, '0, 2'b11);
      send_request(vsir_pkg::KIND_WR64, vsir_pkg::ADDR_SIGLBLID, '1, 2'b00);
      send_request(vsir_pkg::KIND_RD32, vsir_pkg::ADDR_SIGLBLID | 16'h0004, '0, 2'b01);
      send_request(vsir_pkg::KIND_RD64, 16'hFFFF, '1, 2'b10);
      send_request(vsir_pkg::KIND_WR32, vsir_pkg::ADDR_IMR, '0, 2'b00);
      send_request(vsir_pkg::KIND_HBLANK, '0, '0, 2'b00);
      send_request(vsir_pkg::KIND_HBLANK, '1, '1, 2'b11);
      send_request(vsir_pkg::KIND_VBLANK, '0, '0, 2'b00);
      send_request(vsir_pkg::KIND_DRAW, vsir_pkg::DRAW_SIGNAL, 64'hFFFF_FFFF_1234_5678, 2'b00);
      send_request(vsir_pkg::KIND_DRAW, vsir_pkg::DRAW_SIGNAL, 64'hFFFF_0000_ABCD_EF01, 2'b00);
      send_request(vsir_pkg::KIND_RD64, vsir_pkg::ADDR_CSR, '0, 2'b01);
      send_request(vsir_pkg::KIND_WR64, vsir_pkg::ADDR_CSR, 64'h0000_0000_0000_000F, 2'b00);
      send_request(vsir_pkg::KIND_RD64, vsir_pkg::ADDR_SIGLBLID, '0, 2'b00);
      send_request(vsir_pkg::KIND_DRAW, vsir_pkg::DRAW_FINISH, '0, 2'b00);
      send_request(vsir_pkg::KIND_FINISH, '0, '0, 2'b00);
      send_request(vsir_pkg::KIND_FINISH, '0, '0, 2'b00);
      send_request(vsir_pkg::KIND_DRAW, vsir_pkg::DRAW_LABEL, 64'h0000_0000_FFFF_FFFF, 2'b00);
      send_request(vsir_pkg::KIND_DRAW, 16'hFFFF, '1, 2'b00);
      send_request(vsir_pkg::KIND_WR64, vsir_pkg::ADDR_EXTWRITE, 64'h1, 2'b00);
      send_request(vsir_pkg::KIND_WR32, vsir_pkg::ADDR_SYNCV, '1, 2'b00);
      send_request(vsir_pkg::KIND_WR64, vsir_pkg::ADDR_SYNCV, 64'h1, 2'b00);
      send_request(vsir_pkg::KIND_FIELD, '0, '0, 2'b00);
      send_request(vsir_pkg::KIND_FIELD, '0, '0, 2'b00);
      send_request(vsir_pkg::KIND_WR32, vsir_pkg::ADDR_CSR, 64'h0000_0000_0000_0200, 2'b00);
      send_request(vsir_pkg::KIND_FIELD, '0, '0, 2'b00);
      send_request(vsir_mirror_pkg::KIND_UNUSED, '1, '1, 2'b11);

      counted = 0;
      paused = 1'b0;
      while (counted < RANDOM_ITEMS) begin
         burst = $urandom_range(1, 24);
         repeat (burst) begin
            r = random_request();
            send_request(r.kind, r.addr, r.wdata, r.fifo);
            if (r.kind <= vsir_pkg::KIND_FIELD) counted++;
         end
         if (!paused && counted >= RANDOM_ITEMS / 2) begin
            paused = 1'b1;
            drain_responses();
         end else if ($urandom_range(0, 2) != 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end

      drain_responses();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mirror.mismatch_count == 0 && mirror.waiting() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin : response_sink
      int unsigned cycle_no;
      int unsigned mode;
      cycle_no = 0;
      forever begin
         mode = $urandom_range(0, 3);
         repeat ($urandom_range(20, 200)) begin
            @(posedge clock);
            cycle_no++;
            if (cycle_no >= HOLD_START && cycle_no < HOLD_START + HOLD_CYCLES) begin
               rsp_tready <= 1'b0;
            end else begin
               case (mode)
                  0: rsp_tready <= 1'b1;
                  1: rsp_tready <= ($urandom_range(0, 1) != 0);
                  2: rsp_tready <= ($urandom_range(0, 3) == 0);
                  default: rsp_tready <= (cycle_no[2:0] != 3'b101 && cycle_no[2:0] != 3'b110);
               endcase
            end
         end
      end
   end

   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
         else quiet++;
      end
      $display("== FAIL ==");
      $finish;
   end

endmodule
